FILE: rtl/gmps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_pkg
// shared sizes, codes and the compute stage type for the grid minimum path sum block
// ----------------------------------------------------------------------------
package gmps_pkg;

    localparam int MAX_COLS     = 1024;
    localparam int COL_BITS     = $clog2(MAX_COLS);
    localparam int COST_BITS    = 16;
    localparam int SUM_BITS     = 32;
    localparam int OUT_BITS     = 32;
    localparam int ROW_BITS     = 16;
    localparam int GCOL_BITS    = 11;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_COLS = 2'd1;

    localparam logic [SUM_BITS-1:0] SUM_LIMIT = {SUM_BITS{1'b1}};

    // item in the compute stage
    typedef struct packed {
        logic [COL_BITS-1:0]  col;
        logic [COST_BITS-1:0] cost;
        logic                 first_row;
        logic                 first_col;
        logic                 end_row;
        logic                 last;
    } s1_info_t;

endpackage

FILE: rtl/gmps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gmps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/gmps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_ctrl
// configuration registers, grid position counters and the compute stage slot
// ----------------------------------------------------------------------------
module gmps_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gmps_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [gmps_pkg::CFG_DAT_BITS-1:0] cfg_data,
    input  logic                             accept,
    input  logic [gmps_pkg::COST_BITS-1:0]   cell_cost,
    input  logic                             s1_fire,
    output logic                             restart,
    output logic [gmps_pkg::COL_BITS-1:0]    rd_col,
    output logic                             s1_valid,
    output gmps_pkg::s1_info_t               s1_info
);
    import gmps_pkg::*;

    logic [ROW_BITS-1:0]  grid_rows_reg;
    logic [GCOL_BITS-1:0] grid_cols_reg;
    logic [COL_BITS-1:0]  col_reg;
    logic [ROW_BITS-1:0]  row_reg;
    logic                 s1_valid_reg;
    s1_info_t             s1_info_reg;

    logic [ROW_BITS-1:0]  rows_eff;
    logic [GCOL_BITS-1:0] cols_eff;
    logic                 end_row;
    logic                 last_row;

    always_comb
    begin
        rows_eff = (grid_rows_reg == '0) ? ROW_BITS'(1) : grid_rows_reg;
        if (grid_cols_reg == '0)
        begin
            cols_eff = GCOL_BITS'(1);
        end
        else if (32'(grid_cols_reg) > 32'(MAX_COLS))
        begin
            cols_eff = GCOL_BITS'(MAX_COLS);
        end
        else
        begin
            cols_eff = grid_cols_reg;
        end
        end_row  = (32'(col_reg) + 32'd1) == 32'(cols_eff);
        last_row = (32'(row_reg) + 32'd1) == 32'(rows_eff);
    end

    assign restart = cfg_write && (cfg_index == CFG_GRID_ROWS || cfg_index == CFG_GRID_COLS);
    assign rd_col  = col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= ROW_BITS'(1);
            grid_cols_reg <= GCOL_BITS'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
                if (cfg_index == CFG_GRID_ROWS)
                begin
                    grid_rows_reg <= cfg_data[ROW_BITS-1:0];
                end
                else
                begin
                    grid_cols_reg <= cfg_data[GCOL_BITS-1:0];
                end
            end
            else if (accept)
            begin
                if (end_row)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_BITS'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_BITS'(1);
                end
            end
        end
    end

    // payload of the compute stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg.col       <= col_reg;
            s1_info_reg.cost      <= cell_cost;
            s1_info_reg.first_row <= (row_reg == '0);
            s1_info_reg.first_col <= (col_reg == '0);
            s1_info_reg.end_row   <= end_row;
            s1_info_reg.last      <= end_row && last_row;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_info  = s1_info_reg;

endmodule

FILE: rtl/gmps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_dp
// compute stage: best sum, row store write back, forwarding and result register
// ----------------------------------------------------------------------------
module gmps_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           restart,
    input  logic                           accept,
    input  logic [gmps_pkg::COL_BITS-1:0]  rd_col,
    input  logic                           s1_valid,
    input  gmps_pkg::s1_info_t             s1_info,
    input  logic [gmps_pkg::SUM_BITS-1:0]  up_rdata,
    output logic                           s1_hold,
    output logic                           s1_fire,
    output logic [gmps_pkg::SUM_BITS-1:0]  wr_sum,
    input  logic                           result_stall,
    output logic                           result_valid,
    output logic [gmps_pkg::OUT_BITS-1:0]  min_path_sum,
    output logic                           saturated
);
    import gmps_pkg::*;

    logic                 left_valid_reg;
    logic [SUM_BITS-1:0]  left_sum_reg;
    logic                 sat_seen_reg;
    logic                 fwd_reg;
    logic [SUM_BITS-1:0]  fwd_data_reg;
    logic                 result_valid_reg;
    logic [OUT_BITS-1:0]  min_path_sum_reg;
    logic                 saturated_reg;

    logic [SUM_BITS-1:0]  up;
    logic [SUM_BITS-1:0]  base;
    logic [SUM_BITS:0]    sum_wide;
    logic [SUM_BITS-1:0]  sum;
    logic                 hit_limit;

    assign s1_hold = s1_valid && s1_info.last && result_valid_reg && result_stall;
    assign s1_fire = s1_valid && !s1_hold;

    always_comb
    begin
        up = fwd_reg ? fwd_data_reg : up_rdata;
        if (s1_info.first_row && s1_info.first_col)
        begin
            base = '0;
        end
        else if (s1_info.first_row)
        begin
            base = left_sum_reg;
        end
        else if (s1_info.first_col)
        begin
            base = up;
        end
        else
        begin
            base = (up < left_sum_reg) ? up : left_sum_reg;
        end
        sum_wide  = {1'b0, base} + (SUM_BITS+1)'(s1_info.cost);
        sum       = sum_wide[SUM_BITS] ? SUM_LIMIT : sum_wide[SUM_BITS-1:0];
        hit_limit = (sum == SUM_LIMIT);
    end

    assign wr_sum = sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_valid_reg   <= 1'b0;
            sat_seen_reg     <= 1'b0;
            fwd_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                left_valid_reg <= 1'b0;
                sat_seen_reg   <= 1'b0;
            end
            else if (s1_fire)
            begin
                left_valid_reg <= !s1_info.end_row;
                sat_seen_reg   <= (sat_seen_reg || hit_limit) && !s1_info.last;
            end

            // same entry read while it is being written: take the new sum next cycle
            if (accept)
            begin
                fwd_reg <= s1_fire && (s1_info.col == rd_col);
            end
            else if (s1_fire)
            begin
                fwd_reg <= 1'b0;
            end

            if (s1_fire && s1_info.last)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            left_sum_reg <= sum;
            fwd_data_reg <= sum;
        end
        if (s1_fire && s1_info.last)
        begin
            min_path_sum_reg <= OUT_BITS'(sum);
            saturated_reg    <= sat_seen_reg || hit_limit;
        end
    end

    assign result_valid = result_valid_reg;
    assign min_path_sum = min_path_sum_reg;
    assign saturated    = saturated_reg;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_info.last) |=> result_valid_reg)
        else $error("last cell did not load the result register");

    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid)
        else $error("forward flag set with no item in the compute stage");

    a_hold_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        s1_hold |=> s1_valid && $stable(s1_info))
        else $error("held item left the compute stage");

    a_left_only_midrow: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s1_info.first_col) |-> !left_valid_reg)
        else $error("left sum carried into a new row");

endmodule

FILE: rtl/grid_min_path_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_path_sum
// streaming minimum path sum over a grid of cell costs, one row of best sums
// ----------------------------------------------------------------------------
// usage
//   cell channel: cell_cost with cell_valid / cell_stall, costs in row-major
//   order; an item is taken at an edge with cell_valid high and cell_stall low
//   result channel: min_path_sum and saturated with result_valid /
//   result_stall; one item after the last cell of every grid
//   config channel: cfg_valid / cfg_ready with cfg_index (0 grid_rows,
//   1 grid_cols) and cfg_data; cfg_ready is always high; a write to either
//   register restarts the grid; write only while the block is idle
//   throughput: one cell per cycle while cell_stall is low, set by one row store
//   read and one write back per cell through the two-stage read / compute pipe
//   result: the last cell goes through the compute stage into the result register
//   stall: a waiting result holds in its register; cells keep flowing until
//   the next grid's last cell reaches the compute stage, then cell_stall rises
//   reset: grid is 1 x 1 and the position is cleared; the row store needs no
//   clearing since the first row never uses what it reads from it
// ----------------------------------------------------------------------------
module grid_min_path_sum (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gmps_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [gmps_pkg::CFG_DAT_BITS-1:0] cfg_data,
    input  logic                              cell_valid,
    output logic                              cell_stall,
    input  logic [gmps_pkg::COST_BITS-1:0]    cell_cost,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [gmps_pkg::OUT_BITS-1:0]     min_path_sum,
    output logic                              saturated
);
    import gmps_pkg::*;

    logic                cfg_write;
    logic                accept;
    logic                restart;
    logic [COL_BITS-1:0] rd_col;
    logic                s1_valid;
    s1_info_t            s1_info;
    logic                s1_hold;
    logic                s1_fire;
    logic [SUM_BITS-1:0] wr_sum;
    logic [SUM_BITS-1:0] up_rdata;

    // config is taken at any time; the user keeps writes to idle periods
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // a cell enters unless the compute stage holds a last cell behind a busy result
    assign cell_stall = s1_hold;
    assign accept     = cell_valid && !cell_stall;

    gmps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cell_cost (cell_cost),
        .s1_fire   (s1_fire),
        .restart   (restart),
        .rd_col    (rd_col),
        .s1_valid  (s1_valid),
        .s1_info   (s1_info)
    );

    // row store: best sums of the row above, read at accept, written at compute
    gmps_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (MAX_COLS)
    ) u_row_store (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_info.col),
        .wdata (wr_sum),
        .re    (accept),
        .raddr (rd_col),
        .rdata (up_rdata)
    );

    gmps_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .accept       (accept),
        .rd_col       (rd_col),
        .s1_valid     (s1_valid),
        .s1_info      (s1_info),
        .up_rdata     (up_rdata),
        .s1_hold      (s1_hold),
        .s1_fire      (s1_fire),
        .wr_sum       (wr_sum),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .min_path_sum (min_path_sum),
        .saturated    (saturated)
    );

endmodule

FILE: tb/sv/grid_min_path_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_path_sum_checker
// watches the config, cell and result channels, keeps its own copy of the
// path sum recurrence and compares every result item against it
// ----------------------------------------------------------------------------
module grid_min_path_sum_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [gmps_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [gmps_pkg::CFG_DAT_BITS-1:0] cfg_data,
    input  logic                              cell_valid,
    input  logic                              cell_stall,
    input  logic [gmps_pkg::COST_BITS-1:0]    cell_cost,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic [gmps_pkg::OUT_BITS-1:0]     min_path_sum,
    input  logic                              saturated,
    output int unsigned                       pending,
    output int unsigned                       errors
);
    import gmps_pkg::*;

    typedef struct packed {
        logic [OUT_BITS-1:0] path_sum;
        logic                sat_hit;
    } path_result_t;

    path_result_t         expected_paths [$];
    logic [SUM_BITS-1:0]  row_sums [MAX_COLS];
    logic [SUM_BITS-1:0]  run_left;
    int unsigned          col_pos;
    int unsigned          row_pos;
    logic                 grid_sat;
    logic [ROW_BITS-1:0]  rows_reg;
    logic [GCOL_BITS-1:0] cols_reg;
    logic                 unknown_seen;

    function automatic logic [SUM_BITS-1:0] clip_add(input logic [SUM_BITS-1:0] a,
                                                     input logic [COST_BITS-1:0] b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + b;
        return s[SUM_BITS] ? SUM_LIMIT : s[SUM_BITS-1:0];
    endfunction

    task restart_grid();
        run_left = '0;
        col_pos  = 0;
        row_pos  = 0;
        grid_sat = 1'b0;
    endtask

    // one cell of the recurrence, queues the path sum after the last cell
    task take_cell(input logic [COST_BITS-1:0] cost);
        int unsigned         n_rows;
        int unsigned         n_cols;
        int unsigned         col;
        logic [SUM_BITS-1:0] best;
        logic [SUM_BITS-1:0] above;
        n_rows = (rows_reg == 0) ? 1 : rows_reg;
        n_cols = (cols_reg == 0) ? 1 : cols_reg;
        if (n_cols > MAX_COLS)
            n_cols = MAX_COLS;
        col = (col_pos < MAX_COLS) ? col_pos : 0;

        if (row_pos == 0 && col == 0)
            best = cost;
        else if (row_pos == 0)
            best = clip_add(run_left, cost);
        else if (col == 0)
            best = clip_add(row_sums[0], cost);
        else
        begin
            above = row_sums[col];
            best  = clip_add((above < run_left) ? above : run_left, cost);
        end

        row_sums[col] = best;
        run_left      = best;
        if (best == SUM_LIMIT)
            grid_sat = 1'b1;

        if (col + 1 < n_cols)
        begin
            col_pos = col + 1;
            return;
        end
        col_pos  = 0;
        run_left = '0;
        if (row_pos + 1 < n_rows)
        begin
            row_pos = row_pos + 1;
            return;
        end
        expected_paths.push_back('{path_sum: best[OUT_BITS-1:0], sat_hit: grid_sat});
        restart_grid();
    endtask

    task check_result();
        path_result_t want;
        if (expected_paths.size() == 0)
        begin
            errors++;
            $display("%0t: result item with none expected: min_path_sum %0d saturated %0b",
                     $time, min_path_sum, saturated);
            return;
        end
        want = expected_paths.pop_front();
        if (min_path_sum !== want.path_sum)
        begin
            errors++;
            $display("%0t: min_path_sum mismatch: expected %0d, actual %0d",
                     $time, want.path_sum, min_path_sum);
        end
        if (saturated !== want.sat_hit)
        begin
            errors++;
            $display("%0t: saturated mismatch: expected %0b, actual %0b",
                     $time, want.sat_hit, saturated);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     = 1;
            cols_reg     = 1;
            unknown_seen = 1'b0;
            restart_grid();
            expected_paths.delete();
            pending = 0;
        end
        else
        begin
            // report unknown handshake outputs once, count them every cycle
            if ($isunknown({result_valid, cell_stall, cfg_ready}))
            begin
                errors++;
                if (!unknown_seen)
                    $display("%0t: unknown handshake: result_valid %b cell_stall %b cfg_ready %b",
                             $time, result_valid, cell_stall, cfg_ready);
                unknown_seen = 1'b1;
            end
            if (result_valid && !result_stall)
                check_result();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_GRID_ROWS)
                begin
                    rows_reg = cfg_data[ROW_BITS-1:0];
                    restart_grid();
                end
                else if (cfg_index == CFG_GRID_COLS)
                begin
                    cols_reg = cfg_data[GCOL_BITS-1:0];
                    restart_grid();
                end
            end
            if (cell_valid && !cell_stall)
                take_cell(cell_cost);
            pending = expected_paths.size();
        end
    end

endmodule

FILE: tb/sv/grid_min_path_sum_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_path_sum_test
// drives grids of cell costs and grid sizes into the path sum block, with
// bursty cells and a stalling result side; a checker beside the block
// predicts every path sum and counts mismatches, the top gives the verdict
// ----------------------------------------------------------------------------
module grid_min_path_sum_test;
    import gmps_pkg::*;

    // generous bound: the slowest legal run stays well below this
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    // drain after every expected result is checked, leave some margin
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS = 400;

    // how cell costs are drawn for a grid
    typedef enum int unsigned {
        COST_ANY,
        COST_LOW,
        COST_TOP,
        COST_EDGE
    } cost_style_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DAT_BITS-1:0] cfg_data;
    logic                    cell_valid;
    logic                    cell_stall;
    logic [COST_BITS-1:0]    cell_cost;
    logic                    result_valid;
    logic                    result_stall;
    logic [OUT_BITS-1:0]     min_path_sum;
    logic                    saturated;

    int unsigned pending;
    int unsigned errors;
    int unsigned cycle_count = 0;

    // grid size as the block sees it, used to send whole grids
    int unsigned rows_eff;
    int unsigned cols_eff;

    // sender pacing: bursts of up to burst_max items, gaps of up to gap_max
    int unsigned gap_max;
    int unsigned burst_max;
    int unsigned burst_left;

    grid_min_path_sum i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_cost    (cell_cost),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .min_path_sum (min_path_sum),
        .saturated    (saturated)
    );

    grid_min_path_sum_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_cost    (cell_cost),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .min_path_sum (min_path_sum),
        .saturated    (saturated),
        .pending      (pending),
        .errors       (errors)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // run bound
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side stall pattern: free stretches, short stalls, long stalls
    initial
    begin
        int unsigned run_len;
        result_stall = 1'b0;
        run_len      = 0;
        forever
        begin
            @(negedge clk);
            if (run_len != 0)
                run_len--;
            else
            begin
                case ($urandom_range(9, 0))
                    0, 1, 2, 3:
                    begin
                        result_stall <= 1'b0;
                        run_len = $urandom_range(40, 1);
                    end
                    4, 5, 6, 7:
                    begin
                        result_stall <= 1'b1;
                        run_len = $urandom_range(6, 1);
                    end
                    default:
                    begin
                        result_stall <= 1'b1;
                        run_len = $urandom_range(40, 10);
                    end
                endcase
            end
        end
    end

    function automatic logic [COST_BITS-1:0] pick_cost(input cost_style_t style);
        case (style)
            COST_LOW:  return COST_BITS'($urandom_range(15, 0));
            COST_TOP:  return '1;
            COST_EDGE: return $urandom_range(1, 0) ? '1 : '0;
            default:   return COST_BITS'($urandom);
        endcase
    endfunction

    task automatic set_pace(input int unsigned gaps, input int unsigned bursts);
        gap_max    = gaps;
        burst_max  = bursts;
        burst_left = $urandom_range(bursts, 1);
    endtask

    // after an item: close the burst with a random gap once it runs out
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left != 0)
            burst_left--;
        if (gap_max == 0 || burst_left != 0)
            return;
        gap = $urandom_range(gap_max, 1);
        cell_valid <= 1'b0;
        cell_cost  <= COST_BITS'($urandom);
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(burst_max, 1);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_cell(input logic [COST_BITS-1:0] cost);
        cell_valid <= 1'b1;
        cell_cost  <= cost;
        do
            @(posedge clk);
        while (cell_stall);
        @(negedge clk);
        pace_sender();
    endtask

    task automatic send_grid(input cost_style_t style);
        for (int unsigned i = 0; i < rows_eff * cols_eff; i++)
            push_cell(pick_cost(style));
    endtask

    // wait until every path sum is in, then let the pipe run empty
    task automatic settle();
        cell_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // leaves cfg_valid high so that writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DAT_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        // zero means one, cols are 11 bits wide and clamp at the store depth
        if (idx == CFG_GRID_ROWS)
            rows_eff = (data == 0) ? 1 : data;
        else if (idx == CFG_GRID_COLS)
        begin
            cols_eff = data[GCOL_BITS-1:0];
            if (cols_eff == 0)
                cols_eff = 1;
            else if (cols_eff > MAX_COLS)
                cols_eff = MAX_COLS;
        end
    endtask

    initial
    begin
        int unsigned random_items;
        int unsigned grids;
        int unsigned cells;
        int unsigned rows_val;
        int unsigned cols_val;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_GRID_ROWS;
        cfg_data   = '0;
        cell_valid = 1'b0;
        cell_cost  = '0;
        rows_eff   = 1;
        cols_eff   = 1;
        set_pace(0, 1);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 1 x 1 grid out of reset, cost extremes
        push_cell('0);
        push_cell('1);
        settle();

        // 2 x 3 grid where the min over up and left decides the path
        write_reg(CFG_GRID_ROWS, 2);
        write_reg(CFG_GRID_COLS, 3);
        cfg_valid <= 1'b0;
        set_pace(2, 3);
        push_cell(1);
        push_cell(3);
        push_cell(1);
        push_cell(1);
        push_cell(5);
        push_cell(1);
        // same shape with alternating extreme costs
        push_cell('1);
        push_cell('0);
        push_cell('1);
        push_cell('0);
        push_cell('1);
        push_cell('0);
        settle();

        // a config write in the middle of a grid starts it over
        write_reg(CFG_GRID_COLS, 2);
        cfg_valid <= 1'b0;
        push_cell(7);
        push_cell(9);
        push_cell(11);
        settle();
        write_reg(CFG_GRID_COLS, 2);
        cfg_valid <= 1'b0;
        push_cell(4);
        push_cell(2);
        push_cell(8);
        push_cell(3);
        settle();

        // zero rows and zero columns behave as one
        write_reg(CFG_GRID_ROWS, 0);
        write_reg(CFG_GRID_COLS, 0);
        cfg_valid <= 1'b0;
        push_cell(pick_cost(COST_ANY));
        push_cell(pick_cost(COST_ANY));
        settle();

        // column data above the register width is dropped: 1 x 2
        write_reg(CFG_GRID_ROWS, 1);
        write_reg(CFG_GRID_COLS, 16'hF802);
        cfg_valid <= 1'b0;
        push_cell(pick_cost(COST_ANY));
        push_cell(pick_cost(COST_ANY));
        settle();

        // writes to unused indexes leave the grid alone
        for (int idx = CFG_GRID_COLS + 1; idx < (1 << CFG_IDX_BITS); idx++)
            write_reg(CFG_IDX_BITS'(idx), CFG_DAT_BITS'($urandom));
        cfg_valid <= 1'b0;
        push_cell(pick_cost(COST_ANY));
        push_cell(pick_cost(COST_ANY));
        settle();

        // column count above the store depth clamps to it: a short part of
        // the first row gives no result, the next write starts over
        write_reg(CFG_GRID_ROWS, 1);
        write_reg(CFG_GRID_COLS, 2047);
        cfg_valid <= 1'b0;
        set_pace(2, 8);
        repeat (24) push_cell(pick_cost(COST_LOW));
        settle();

        // random grids, mostly small, with random sizes, pacing and costs
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(4, 0) == 0)
            begin
                // run of 1 x 1 grids at full rate to fill up the result side
                rows_val = $urandom_range(1, 0);
                cols_val = $urandom_range(1, 0);
                grids    = $urandom_range(12, 4);
                set_pace(0, 1);
            end
            else
            begin
                rows_val = $urandom_range(6, 0);
                cols_val = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1)
                                                       : $urandom_range(8, 0);
                if ($urandom_range(3, 0) == 0)
                    cols_val = cols_val | ($urandom_range(31, 1) << GCOL_BITS);
                grids = $urandom_range(4, 1);
                set_pace($urandom_range(1, 0) ? 0 : $urandom_range(8, 1),
                         $urandom_range(16, 1));
            end

            if ($urandom_range(1, 0))
            begin
                write_reg(CFG_GRID_ROWS, CFG_DAT_BITS'(rows_val));
                write_reg(CFG_GRID_COLS, CFG_DAT_BITS'(cols_val));
            end
            else
            begin
                write_reg(CFG_GRID_COLS, CFG_DAT_BITS'(cols_val));
                write_reg(CFG_GRID_ROWS, CFG_DAT_BITS'(rows_val));
            end
            cfg_valid <= 1'b0;

            for (int unsigned g = 0; g < grids; g++)
            begin
                send_grid(cost_style_t'($urandom_range(3, 0)));
                random_items += rows_eff * cols_eff;
            end

            // now and then a grid cut short, the next config write restarts it
            if ($urandom_range(3, 0) == 0 && rows_eff * cols_eff > 1)
            begin
                cells = $urandom_range(rows_eff * cols_eff - 1, 1);
                repeat (cells) push_cell(pick_cost(COST_ANY));
            end
            settle();
        end

        settle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
